/* rtl/lrk_pkg.sv */
package lrk_pkg;

  // Default number of entries held by the store.
  localparam int unsigned LRK_CAPACITY = 16;

  // Payload widths fixed by the item format.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POLL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Status codes returned with each result item.
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input item and register the key match
    logic apply;    // update the cells and load the result register
  } lrk_ctl_t;

endpackage

/* rtl/lrk_in_if.sv */
interface lrk_in_if
  import lrk_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key_value;
  logic [SIZE_W-1:0] object_size;

  modport source (output valid, cmd, key_value, object_size, input ready);
  modport sink   (input valid, cmd, key_value, object_size, output ready);
endinterface

/* rtl/lrk_out_if.sv */
interface lrk_out_if
  import lrk_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    found_key;
  logic [SIZE_W-1:0]   found_size;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_key, found_size, entry_count, input ready);
  modport sink   (input valid, status, found_key, found_size, entry_count, output ready);
endinterface

/* rtl/lrk_ctrl.sv */
module lrk_ctrl
  import lrk_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lrk_ctl_t ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // An item is taken only in idle; the pending result may still sit in the output register.
  assign in_ready_o    = (state_q == S_IDLE);
  assign ctl_o.capture = in_valid_i && (state_q == S_IDLE);
  assign ctl_o.apply   = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;

  // Next state and output register occupancy.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!out_valid_q || out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/lrk_datapath.sv */
module lrk_datapath
  import lrk_pkg::*;
#(
  parameter int unsigned CAPACITY = LRK_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrk_ctl_t            ctl_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [KEY_W-1:0]    key_value_i,
  input  logic [SIZE_W-1:0]   object_size_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [KEY_W-1:0]    found_key_o,
  output logic [SIZE_W-1:0]   found_size_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  // Cell chain: cell 0 is the most recent entry.
  logic [KEY_W-1:0]  key_q  [CAPACITY];
  logic [KEY_W-1:0]  key_d  [CAPACITY];
  logic [SIZE_W-1:0] size_q [CAPACITY];
  logic [SIZE_W-1:0] size_d [CAPACITY];
  logic [CntW-1:0]   count_q, count_d;

  // Latched operation and the match vector found at capture.
  logic [CMD_W-1:0]    op_cmd_q;
  logic [KEY_W-1:0]    op_key_q;
  logic [SIZE_W-1:0]   op_size_q;
  logic [CAPACITY-1:0] match_q, match_d;

  // Result register.
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;
  logic [SIZE_W-1:0]   res_size_q, res_size_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;

  logic [CAPACITY-1:0] last_vec;
  logic [CAPACITY-1:0] sel_vec;
  logic [IdxW-1:0]     pos;
  logic                hit;
  logic                full;
  logic                empty;
  logic                add_go;
  logic                rem_go;
  logic [KEY_W-1:0]    sel_key;
  logic [SIZE_W-1:0]   sel_size;
  logic [CntW+COUNT_W-1:0] count_ext;

  // Every held cell compares its key against the incoming one.
  always_comb begin
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      match_d[i] = (key_q[i] == key_value_i) && (CntW'(i) < count_q);
    end
  end

  // Position of the hit and the least recent cell, both as one-hot or index.
  always_comb begin
    pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) begin
        pos = pos | IdxW'(i);
      end
      last_vec[i] = (count_q != '0) && (CntW'(i) == count_q - CntW'(1));
    end
  end

  assign hit    = |match_q;
  assign full   = (count_q == CntFull);
  assign empty  = (count_q == '0);
  assign add_go = (op_cmd_q == CMD_ADD) && (hit || !full);
  assign rem_go = (op_cmd_q == CMD_REMOVE) && hit;

  // One-hot read of the evicted or removed cell.
  assign sel_vec = (op_cmd_q == CMD_POLL) ? last_vec : match_q;

  always_comb begin
    sel_key  = '0;
    sel_size = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (sel_vec[i]) begin
        sel_key  = sel_key | key_q[i];
        sel_size = sel_size | size_q[i];
      end
    end
  end

  // Next value of each cell: shift older on add, shift younger on remove.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      always_comb begin
        key_d[g]  = key_q[g];
        size_d[g] = size_q[g];
        if (add_go) begin
          key_d[g]  = op_key_q;
          size_d[g] = op_size_q;
        end else if (rem_go && (pos == '0) && (CAPACITY > 1)) begin
          key_d[g]  = key_q[(CAPACITY > 1) ? 1 : 0];
          size_d[g] = size_q[(CAPACITY > 1) ? 1 : 0];
        end
      end
    end else if (g == CAPACITY - 1) begin : g_tail
      always_comb begin
        key_d[g]  = key_q[g];
        size_d[g] = size_q[g];
        if (add_go && (!hit || (IdxW'(g) <= pos))) begin
          key_d[g]  = key_q[g-1];
          size_d[g] = size_q[g-1];
        end
      end
    end else begin : g_mid
      always_comb begin
        key_d[g]  = key_q[g];
        size_d[g] = size_q[g];
        if (add_go && (!hit || (IdxW'(g) <= pos))) begin
          key_d[g]  = key_q[g-1];
          size_d[g] = size_q[g-1];
        end else if (rem_go && (IdxW'(g) >= pos)) begin
          key_d[g]  = key_q[g+1];
          size_d[g] = size_q[g+1];
        end
      end
    end
  end

  // Entry count and the result item.
  always_comb begin
    count_d      = count_q;
    res_status_d = ST_MISS;
    res_key_d    = '0;
    res_size_d   = '0;
    case (op_cmd_q)
      CMD_ADD: begin
        if (hit) begin
          res_status_d = ST_DONE;
        end else if (full) begin
          res_status_d = ST_FULL;
        end else begin
          res_status_d = ST_DONE;
          count_d      = count_q + CntW'(1);
        end
      end
      CMD_POLL: begin
        if (!empty) begin
          res_status_d = ST_DONE;
          res_key_d    = sel_key;
          res_size_d   = sel_size;
          count_d      = count_q - CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          res_status_d = ST_DONE;
          res_key_d    = sel_key;
          res_size_d   = sel_size;
          count_d      = count_q - CntW'(1);
        end
      end
      default: ;
    endcase
    count_ext   = {{COUNT_W{1'b0}}, count_d};
    res_count_d = count_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.apply) begin
      count_q <= count_d;
    end
  end

  // Cells, latched operation and result hold payload only.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_cmd_q  <= cmd_i;
      op_key_q  <= key_value_i;
      op_size_q <= object_size_i;
      match_q   <= match_d;
    end
    if (ctl_i.apply) begin
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        key_q[i]  <= key_d[i];
        size_q[i] <= size_d[i];
      end
      res_status_q <= res_status_d;
      res_key_q    <= res_key_d;
      res_size_q   <= res_size_d;
      res_count_q  <= res_count_d;
    end
  end

  assign status_o      = res_status_q;
  assign found_key_o   = res_key_q;
  assign found_size_o  = res_size_q;
  assign entry_count_o = res_count_q;

endmodule

/* rtl/lru_recency_key_list.sv */
// Recency-ordered key store for LRU replacement.
// Input channel in_i carries cmd (add or touch, poll, remove), key_value and
// object_size. Output channel out_o returns one item per input item with
// status, found_key, found_size and entry_count, in input order.
// In the accept cycle every cell compares its key with the incoming key and
// the match vector is registered; in the update state the cell chain shifts
// by one place and the result register loads.
// A new item is accepted only after the previous one has left the update state.
// The result register decouples the sides: the next item is accepted while
// a result still waits, and that item then holds in its update cycle until
// the output register is taken.
// Reset empties the store at once (entry count zero) and drops any pending
// result; key and size cells need no clearing since only held cells are read.
// CAPACITY sets the number of cells; entry_count carries the low five bits
// of the held count.
module lru_recency_key_list
  import lrk_pkg::*;
#(
  parameter int unsigned CAPACITY = LRK_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrk_in_if.sink     in_i,
  lrk_out_if.source  out_o
);

  lrk_ctl_t ctl;

  // Sequencer for capture and update.
  lrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctl_o       (ctl)
  );

  // Cell chain, match logic and result register.
  lrk_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .cmd_i         (in_i.cmd),
    .key_value_i   (in_i.key_value),
    .object_size_i (in_i.object_size),
    .status_o      (out_o.status),
    .found_key_o   (out_o.found_key),
    .found_size_o  (out_o.found_size),
    .entry_count_o (out_o.entry_count)
  );

endmodule
